>>> sv/gpio_interrupt_register_block_unit_macros.svh
// Assertion helpers for the GPIO interrupt register block unit.
`ifndef GPIO_INTERRUPT_REGISTER_BLOCK_UNIT_MACROS_SVH
`define GPIO_INTERRUPT_REGISTER_BLOCK_UNIT_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define GIRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clk_i edge, reset included.
`define GIRQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/gpioirq_pkg.sv
package gpioirq_pkg;

  localparam int unsigned PinCountDefault = 32;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned OffsetWidth     = 12;

  // Access kinds
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Register byte offsets
  localparam logic [OffsetWidth-1:0] OffDir  = 12'h000;
  localparam logic [OffsetWidth-1:0] OffOut  = 12'h004;
  localparam logic [OffsetWidth-1:0] OffIn   = 12'h008;
  localparam logic [OffsetWidth-1:0] OffIe   = 12'h00c;
  localparam logic [OffsetWidth-1:0] OffIs   = 12'h010;
  localparam logic [OffsetWidth-1:0] OffTrig = 12'h014;
  localparam logic [OffsetWidth-1:0] OffPol  = 12'h018;

  typedef struct packed {
    logic                   op;
    logic [OffsetWidth-1:0] offset;
    logic [DataWidth-1:0]   wdata;
  } gpioirq_access_t;

endpackage

>>> sv/gpioirq_core.sv
module gpioirq_core #(
  parameter int unsigned PinCount = gpioirq_pkg::PinCountDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  gpioirq_pkg::gpioirq_access_t      acc_i,
  output logic [gpioirq_pkg::DataWidth-1:0] rd_data_o,
  output logic                              irq_o,
  output logic                              irq_line_o
);
  import gpioirq_pkg::*;

  logic [PinCount-1:0] dir_q, dir_d;
  logic [PinCount-1:0] out_q, out_d;
  logic [PinCount-1:0] in_q, in_d;
  logic [PinCount-1:0] ie_q, ie_d;
  logic [PinCount-1:0] is_q, is_d;
  logic [PinCount-1:0] trig_q, trig_d;
  logic [PinCount-1:0] pol_q, pol_d;
  logic                irq_line_q, irq_line_d;

  logic [PinCount-1:0] val;
  logic [PinCount-1:0] rise, fall, edge_hit, level_hit, drive_status;
  logic [DataWidth-1:0] rd;

  assign val  = acc_i.wdata[PinCount-1:0];
  assign rise = ~out_q & val;
  assign fall = out_q & ~val;
  assign edge_hit  = ((rise & pol_q) | (fall & ~pol_q)) & ~trig_q;
  assign level_hit = ((val & pol_q) | (~val & ~pol_q)) & trig_q;
  assign drive_status = (level_hit | (is_q & ~trig_q) | edge_hit) & ie_q;

  always_comb begin
    dir_d      = dir_q;
    out_d      = out_q;
    in_d       = in_q;
    ie_d       = ie_q;
    is_d       = is_q;
    trig_d     = trig_q;
    pol_d      = pol_q;
    irq_line_d = irq_line_q;
    rd         = '0;
    if (acc_i.op == OpWrite) begin
      unique case (acc_i.offset)
        OffDir:  dir_d = val;
        OffOut: begin
          out_d      = val;
          in_d       = val;
          is_d       = drive_status;
          irq_line_d = |drive_status;
        end
        OffIe: begin
          ie_d       = val;
          irq_line_d = |(is_q & val);
        end
        OffIs: begin
          is_d       = is_q & ~val;
          irq_line_d = |(is_q & ~val & ie_q);
        end
        OffTrig: trig_d = val;
        OffPol:  pol_d  = val;
        default: ;
      endcase
    end else begin
      unique case (acc_i.offset)
        OffDir:  rd[PinCount-1:0] = dir_q;
        OffOut:  rd[PinCount-1:0] = out_q;
        OffIn:   rd[PinCount-1:0] = in_q;
        OffIe:   rd[PinCount-1:0] = ie_q;
        OffIs:   rd[PinCount-1:0] = is_q;
        OffTrig: rd[PinCount-1:0] = trig_q;
        OffPol:  rd[PinCount-1:0] = pol_q;
        default: rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= '0;
      out_q      <= '0;
      in_q       <= '0;
      ie_q       <= '0;
      is_q       <= '0;
      trig_q     <= '0;
      pol_q      <= '0;
      irq_line_q <= 1'b0;
    end else if (en_i) begin
      dir_q      <= dir_d;
      out_q      <= out_d;
      in_q       <= in_d;
      ie_q       <= ie_d;
      is_q       <= is_d;
      trig_q     <= trig_d;
      pol_q      <= pol_d;
      irq_line_q <= irq_line_d;
    end
  end

  assign rd_data_o  = rd;
  assign irq_o      = irq_line_d;
  assign irq_line_o = irq_line_q;

endmodule

>>> sv/gpio_interrupt_register_block_unit.sv
// Path: an accepted bus word passes through two registers, the access register and then the result register.
// Throughput: one word per cycle; the access register and the result register stall
// together only when the result is not taken.
// Reset (rst_ni low, asynchronous): every GPIO register, the interrupt line and
// both valid flags clear to zero.
module gpio_interrupt_register_block_unit #(
  parameter int unsigned PinCount = gpioirq_pkg::PinCountDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [gpioirq_pkg::OffsetWidth-1:0] offset_i,
  input  logic [gpioirq_pkg::DataWidth-1:0]   write_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gpioirq_pkg::DataWidth-1:0]   read_data_o,
  output logic                                irq_o
);
  import gpioirq_pkg::*;

  `include "gpio_interrupt_register_block_unit_macros.svh"

  // Access register: holds the accepted bus word until the register file
  // has processed it.
  logic            acc_valid_q;
  gpioirq_access_t acc_q;

  // Result register: holds read data and line level until taken.
  logic                 res_valid_q;
  logic [DataWidth-1:0] read_data_q;
  logic                 irq_q;

  logic                 advance;
  logic [DataWidth-1:0] core_rd;
  logic                 core_irq;
  logic                 irq_line;

  // Advance the access word into the result register whenever that slot is
  // free or being emptied this cycle; the register file commits at the same edge,
  // so state changes stay in bus order.
  assign advance    = acc_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !acc_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      acc_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      acc_q.op     <= op_i;
      acc_q.offset <= offset_i;
      acc_q.wdata  <= write_data_i;
    end
  end

  gpioirq_core #(
    .PinCount(PinCount)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .acc_i     (acc_q),
    .rd_data_o (core_rd),
    .irq_o     (core_irq),
    .irq_line_o(irq_line)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      irq_q       <= 1'b0;
    end else begin
      if (advance) begin
        res_valid_q <= 1'b1;
        irq_q       <= core_irq;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_data_q <= core_rd;
    end
  end

  assign out_valid_o = res_valid_q;
  assign read_data_o = read_data_q;
  assign irq_o       = irq_q;

  // The shown line level always matches the committed register-file state.
  `GIRQ_ASSERT_ALWAYS(a_irq_matches_line, irq_o == irq_line, "irq output out of step with state")
  // A write word returns zero read data.
  `GIRQ_ASSERT(a_write_reads_zero, (advance && acc_q.op == OpWrite) |=> (read_data_o == '0), "write returned nonzero read data")
  // A full access register behind a stalled result refuses new words.
  `GIRQ_ASSERT(a_stall_blocks_input, (acc_valid_q && res_valid_q && !out_ready_i) |-> !in_ready_o, "input taken while pipeline stalled")

endmodule

>>> tb/gpio_reg_shadow.sv
module gpio_reg_shadow
  import gpioirq_pkg::*;
#(
  parameter int unsigned PinCount = PinCountDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   op_i,
  input  logic [OffsetWidth-1:0] offset_i,
  input  logic [DataWidth-1:0]   write_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [DataWidth-1:0]   read_data_i,
  input  logic                   irq_i,
  output int unsigned            pending_o,
  output int unsigned            mismatches_o
);

  localparam logic [DataWidth-1:0] PinMask = (PinCount >= DataWidth) ? {DataWidth{1'b1}} :
                                             ((DataWidth'(1) << PinCount) - 1'b1);

  typedef struct packed {
    logic [DataWidth-1:0] rdata;
    logic                 irq;
  } word_result_t;

  // Shadow copy of the register file
  logic [DataWidth-1:0] dir_q, out_q, in_q, ie_q, is_q, trig_q, pol_q;
  logic                 line_q;

  word_result_t due_results[$];
  word_result_t want;

  // Apply one bus word to the shadow registers and return what the block must answer.
  function automatic word_result_t apply_bus_word(logic op, logic [OffsetWidth-1:0] off,
                                                  logic [DataWidth-1:0] wdata);
    word_result_t         res;
    logic [DataWidth-1:0] val, rise, fall, edge_hit, level_hit;
    val       = wdata & PinMask;
    res.rdata = '0;
    if (op == OpWrite) begin
      case (off)
        OffDir:  dir_q = val;
        OffOut: begin
          rise      = ~out_q & val;
          fall      = out_q & ~val;
          edge_hit  = ((rise & pol_q) | (fall & ~pol_q)) & ~trig_q;
          level_hit = ((val & pol_q) | (~val & ~pol_q)) & trig_q;
          out_q     = val;
          in_q      = val;
          is_q      = (level_hit | (is_q & ~trig_q) | edge_hit) & ie_q & PinMask;
          line_q    = |(is_q & ie_q);
        end
        OffIe: begin
          ie_q   = val;
          line_q = |(is_q & ie_q);
        end
        OffIs: begin
          is_q   = is_q & ~val;
          line_q = |(is_q & ie_q);
        end
        OffTrig: trig_q = val;
        OffPol:  pol_q  = val;
        default: ;
      endcase
    end else begin
      case (off)
        OffDir:  res.rdata = dir_q;
        OffOut:  res.rdata = out_q;
        OffIn:   res.rdata = in_q;
        OffIe:   res.rdata = ie_q;
        OffIs:   res.rdata = is_q;
        OffTrig: res.rdata = trig_q;
        OffPol:  res.rdata = pol_q;
        default: res.rdata = '0;
      endcase
    end
    res.irq = line_q;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  initial mismatches_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  = '0;
      out_q  = '0;
      in_q   = '0;
      ie_q   = '0;
      is_q   = '0;
      trig_q = '0;
      pol_q  = '0;
      line_q = 1'b0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        due_results.push_back(apply_bus_word(op_i, offset_i, write_data_i));
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (rdata %h irq %b)",
                                    read_data_i, irq_i));
        end else begin
          want = due_results.pop_front();
          if (read_data_i !== want.rdata)
            report_mismatch($sformatf("read_data got %h want %h", read_data_i, want.rdata));
          if (irq_i !== want.irq)
            report_mismatch($sformatf("irq got %b want %b", irq_i, want.irq));
        end
      end
      pending_o <= due_results.size();
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  import gpioirq_pkg::*;

  // Generous bound: ~525 words, each at worst a full send gap plus a full
  // receive stall plus the pass through both registers, taken several times over.
  localparam int unsigned ItemTarget = 500;
  localparam int unsigned CycleLimit = 200000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   op_i;
  logic [OffsetWidth-1:0] offset_i;
  logic [DataWidth-1:0]   write_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [DataWidth-1:0]   read_data_o;
  logic                   irq_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count = 0;

  // Idle odds in percent for the sender (per word) and the receiver; zero turns idling off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Last value written to the output register, used to build small pin flips.
  logic [DataWidth-1:0] last_out = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  gpio_interrupt_register_block_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .offset_i     (offset_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .irq_o        (irq_o)
  );

  gpio_reg_shadow u_shadow (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .op_i         (op_i),
    .offset_i     (offset_i),
    .write_data_i (write_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_i  (read_data_o),
    .irq_i        (irq_o),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: take results, dropping ready for bursts of random length at random.
  initial begin : recv_side
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 19);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Present one bus word and hold it until the block takes it. Optionally drop
  // valid for a random burst first, so gaps land in every phase of the pipe.
  task automatic send_word(logic op, logic [OffsetWidth-1:0] off, logic [DataWidth-1:0] data);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    offset_i     <= off;
    write_data_i <= data;
    if (op == OpWrite && off == OffOut) last_out = data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and hold until every pending result has been taken.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Build one random word. Most words hit a real register, with the output
  // register favored so pin edges and levels keep moving; the rest is
  // unaligned or random offsets.
  task automatic pick_word(output logic op, output logic [OffsetWidth-1:0] off,
                           output logic [DataWidth-1:0] data);
    int unsigned sel;
    op  = ($urandom_range(0, 99) < 60) ? OpWrite : OpRead;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      off = OffsetWidth'($urandom_range(0, 4095));
    end else if (sel < 14) begin
      off = OffsetWidth'(4 * $urandom_range(0, 6) + $urandom_range(1, 3));
    end else begin
      case ($urandom_range(0, 9))
        0:       off = OffDir;
        4:       off = OffIn;
        5:       off = OffIe;
        6:       off = OffIs;
        7:       off = OffTrig;
        8:       off = OffPol;
        default: off = OffOut;
      endcase
    end
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      2:       data = last_out ^ (DataWidth'(1) << $urandom_range(0, DataWidth - 1));
      3:       data = $urandom & $urandom;
      default: data = $urandom;
    endcase
  endtask

  initial begin : stimulus
    logic                   op;
    logic [OffsetWidth-1:0] off;
    logic [DataWidth-1:0]   data;
    int unsigned            done_words;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    op_i         <= OpRead;
    offset_i     <= '0;
    write_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: register extremes, both triggers and polarities, clears,
    // read-only input, unknown and unaligned offsets.
    send_word(OpWrite, OffDir, '1);
    send_word(OpRead,  OffDir, '0);
    send_word(OpWrite, OffDir, '0);
    // Upper half level-triggered, lower half edge; mixed polarity per byte.
    send_word(OpWrite, OffTrig, 32'hffff_0000);
    send_word(OpWrite, OffPol,  32'hff00_ff00);
    send_word(OpWrite, OffIe,   '1);
    send_word(OpWrite, OffOut,  '1);   // rising edges and high levels
    send_word(OpRead,  OffIs,   '0);
    send_word(OpRead,  OffIn,   '0);
    send_word(OpWrite, OffOut,  '0);   // falling edges and low levels
    send_word(OpRead,  OffIs,   '0);
    send_word(OpWrite, OffIs,   32'h0000_00ff);  // partial clear
    send_word(OpWrite, OffIs,   '1);
    send_word(OpWrite, OffOut,  32'h0000_ff00);
    send_word(OpWrite, OffIe,   '0);   // line drops, status kept
    send_word(OpRead,  OffIs,   '0);
    send_word(OpWrite, OffIn,   32'h1234_5678);  // read-only, ignored
    send_word(OpRead,  OffIn,   '0);
    send_word(OpWrite, OffPol + OffsetWidth'(1), '1);  // unaligned, ignored
    send_word(OpRead,  12'hffc, '0);
    send_word(OpRead,  OffIe + OffsetWidth'(2), '0);
    send_word(OpRead,  OffTrig, '0);
    send_word(OpRead,  OffPol,  '0);
    send_word(OpRead,  OffOut,  '0);
    send_word(OpRead,  OffIe,   '0);

    // Random phase one: light idling on both sides.
    send_idle_pct = 12;
    recv_idle_pct = 12;
    done_words    = 0;
    while (done_words < ItemTarget * 2 / 5) begin
      pick_word(op, off, data);
      send_word(op, off, data);
      done_words++;
    end

    // Let the pipe empty completely before going on.
    drain();

    // Random phase two: sender idles rarely, receiver stalls hard.
    send_idle_pct = 5;
    recv_idle_pct = 35;
    while (done_words < ItemTarget * 4 / 5) begin
      pick_word(op, off, data);
      send_word(op, off, data);
      done_words++;
    end

    // Last stretch back to back, no idling anywhere.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (done_words < ItemTarget) begin
      pick_word(op, off, data);
      send_word(op, off, data);
      done_words++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
